@@ rtl/kpsd_pkg.sv @@
// Types and constants shared by the keypad scanner files.
`timescale 1ns / 1ps

package kpsd_pkg;

  typedef enum logic [1:0] {
    OP_SCAN  = 2'd0,
    OP_POP   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  localparam logic [0:0] REG_SHORT_PRESS = 1'b0;
  localparam logic [0:0] REG_LONG_PRESS  = 1'b1;

  localparam logic [7:0] SHORT_PRESS_RESET = 8'd5;
  localparam logic [7:0] LONG_PRESS_RESET  = 8'd25;
  localparam logic [7:0] COUNT_MAX         = 8'hFF;

  typedef struct packed {
    op_t        operation;
    logic [3:0] row_levels;
  } kp_in_t;

  typedef struct packed {
    logic [3:0] column_drive;
    logic       key_valid;
    logic [7:0] key_char;
    logic       key_long;
    logic [4:0] buffered_keys;
  } kp_out_t;

  typedef struct packed {
    logic       reported;
    logic [7:0] count;
  } key_state_t;

  typedef key_state_t [3:0] col_state_t;

  typedef struct packed {
    logic       is_long;
    logic [3:0] key;
  } q_entry_t;

  localparam logic [7:0] KEY_CHARS [16] = '{
    8'h31, 8'h32, 8'h33, 8'h41,
    8'h34, 8'h35, 8'h36, 8'h42,
    8'h37, 8'h38, 8'h39, 8'h43,
    8'h2A, 8'h30, 8'h23, 8'h44
  };

endpackage

@@ rtl/keypad_scan_debounce_fifo.sv @@
// Top level of the 4x4 keypad scanner with press counters and key FIFO.
//
// Usage: each input item carries an operation (scan tick, pop, clear) and the
// sampled row levels. A scan tick updates the four keys of the driven column
// and moves the drive to the next column; a pop returns the oldest key as an
// ASCII code with its long flag; a clear empties the key FIFO.
// Every accepted item yields exactly one result item on the output channel.
// The result is valid in the cycle after acceptance, from an output register.
// One item per cycle while results are taken, set by the per-column
// read-modify-write of the key state memory and the prefetched FIFO head read.
// Up to four keys enter the FIFO per tick through four interleaved banks.
// Configuration writes (short and long thresholds) take effect at once;
// cfg_ready is always high.
// Reset: column zero is driven, counters read as zero through
// per-column valid bits, the FIFO is empty, thresholds return to 5 and 25.
// When the receiver stalls, the result holds and in_ready drops until the
// result is taken; in_ready stays high while the output register drains.
`timescale 1ns / 1ps

module keypad_scan_debounce_fifo #(
  parameter int unsigned FIFO_DEPTH = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  kpsd_pkg::kp_in_t  in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output kpsd_pkg::kp_out_t out_data,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [0:0]      cfg_index,
  input  logic [7:0]      cfg_data
);

  import kpsd_pkg::*;

  localparam int unsigned QSIZE = ((FIFO_DEPTH + 3) / 4) * 4;
  localparam int unsigned ROWS  = QSIZE / 4;
  localparam int unsigned PW    = $clog2(QSIZE);
  localparam int unsigned RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned FW    = $clog2(FIFO_DEPTH + 1);

  localparam logic [PW-1:0] PTR_LAST = PW'(QSIZE - 1);
  localparam logic [FW-1:0] FILL_MAX = FW'(FIFO_DEPTH);

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [RW-1:0] ptr_row(input logic [PW-1:0] p);
    ptr_row = RW'(p >> 2);
  endfunction

  logic [7:0]    short_ticks;
  logic [7:0]    long_ticks;
  logic [1:0]    scan_col;
  logic [1:0]    scan_col_next;
  logic [3:0]    col_valid;
  col_state_t    kmem [4];
  col_state_t    col_rd;
  col_state_t    col_cur;
  col_state_t    col_new;

  q_entry_t      qmem [4][ROWS];
  q_entry_t      q_rd [4];
  logic          fwd_hit;
  q_entry_t      fwd_data;
  q_entry_t      head_ent;

  logic [PW-1:0] head;
  logic [PW-1:0] head_next;
  logic [PW-1:0] tail;
  logic [PW-1:0] tail_next;
  logic [FW-1:0] fill;
  logic [FW-1:0] fill_next;

  logic [PW-1:0] push_pos;
  logic [FW-1:0] scan_fill;
  logic [3:0]    we;
  logic [RW-1:0] wrow  [4];
  q_entry_t      wdata [4];
  logic          fwd_hit_next;

  logic          accept;
  logic          do_scan;
  logic          pop_ok;
  kp_out_t       result;

  assign accept    = in_valid && in_ready;
  assign in_ready  = !out_valid || out_ready;
  assign cfg_ready = 1'b1;
  assign do_scan   = accept && (in_data.operation == OP_SCAN);
  assign pop_ok    = (in_data.operation == OP_POP) && (fill != '0);
  assign head_ent  = fwd_hit ? fwd_data : q_rd[head[1:0]];

  always_comb begin
    col_cur   = col_valid[scan_col] ? col_rd : '0;
    col_new   = col_cur;
    push_pos  = tail;
    scan_fill = fill;
    we        = '0;
    for (int b = 0; b < 4; b++) begin
      wrow[b]  = '0;
      wdata[b] = '0;
    end
    for (int r = 0; r < 4; r++) begin
      if (!in_data.row_levels[r]) begin
        if (col_new[r].count != COUNT_MAX) begin
          col_new[r].count = col_new[r].count + 1'b1;
        end
        if ((col_new[r].count >= long_ticks) && !col_new[r].reported) begin
          col_new[r].reported = 1'b1;
          if (scan_fill == FILL_MAX) begin
            col_new[r].count = '0;
          end else begin
            we[push_pos[1:0]]    = 1'b1;
            wrow[push_pos[1:0]]  = ptr_row(push_pos);
            wdata[push_pos[1:0]] = '{is_long: 1'b1, key: {2'(r), scan_col}};
            push_pos  = ptr_inc(push_pos);
            scan_fill = scan_fill + 1'b1;
          end
        end
      end else begin
        if ((col_new[r].count >= short_ticks) && !col_new[r].reported
            && (scan_fill == FILL_MAX)) begin
          col_new[r].reported = 1'b1;
        end else begin
          if ((col_new[r].count >= short_ticks) && !col_new[r].reported) begin
            we[push_pos[1:0]]    = 1'b1;
            wrow[push_pos[1:0]]  = ptr_row(push_pos);
            wdata[push_pos[1:0]] = '{is_long: 1'b0, key: {2'(r), scan_col}};
            push_pos  = ptr_inc(push_pos);
            scan_fill = scan_fill + 1'b1;
          end
          col_new[r].reported = 1'b0;
        end
        col_new[r].count = '0;
      end
    end
    we = do_scan ? we : 4'b0000;
  end

  always_comb begin
    scan_col_next = scan_col;
    head_next     = head;
    tail_next     = tail;
    fill_next     = fill;
    result        = '0;
    if (accept) begin
      case (in_data.operation)
        OP_SCAN: begin
          scan_col_next = scan_col + 1'b1;
          tail_next     = push_pos;
          fill_next     = scan_fill;
        end
        OP_POP: begin
          if (pop_ok) begin
            head_next = ptr_inc(head);
            fill_next = fill - 1'b1;
          end
        end
        OP_CLEAR: begin
          head_next = '0;
          tail_next = '0;
          fill_next = '0;
        end
        default: begin
        end
      endcase
    end
    result.column_drive  = ~(4'b0001 << scan_col_next);
    result.key_valid     = pop_ok;
    result.key_char      = pop_ok ? KEY_CHARS[head_ent.key] : 8'h00;
    result.key_long      = pop_ok && head_ent.is_long;
    result.buffered_keys = 5'(fill_next);
    fwd_hit_next = we[head_next[1:0]] && (wrow[head_next[1:0]] == ptr_row(head_next));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      short_ticks <= SHORT_PRESS_RESET;
      long_ticks  <= LONG_PRESS_RESET;
      scan_col    <= '0;
      col_valid   <= '0;
      head        <= '0;
      tail        <= '0;
      fill        <= '0;
      out_valid   <= 1'b0;
      fwd_hit     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SHORT_PRESS: short_ticks <= cfg_data;
          REG_LONG_PRESS:  long_ticks  <= cfg_data;
          default: begin
          end
        endcase
      end
      if (do_scan) begin
        col_valid[scan_col] <= 1'b1;
      end
      scan_col <= scan_col_next;
      head     <= head_next;
      tail     <= tail_next;
      fill     <= fill_next;
      fwd_hit  <= fwd_hit_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_scan) begin
      kmem[scan_col] <= col_new;
    end
    col_rd <= kmem[scan_col_next];
  end

  always_ff @(posedge clk) begin
    for (int b = 0; b < 4; b++) begin
      if (we[b]) begin
        qmem[b][wrow[b]] <= wdata[b];
      end
      q_rd[b] <= qmem[b][ptr_row(head_next)];
    end
    fwd_data <= wdata[head_next[1:0]];
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= result;
    end
  end

  logic [PW:0] ptr_sum;
  logic [PW:0] ptr_wrap;

  assign ptr_sum  = {1'b0, head} + (PW + 1)'(fill);
  assign ptr_wrap = (ptr_sum >= (PW + 1)'(QSIZE)) ? ptr_sum - (PW + 1)'(QSIZE) : ptr_sum;

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_MAX)
    else $error("key fifo fill above depth");

  a_ptr_consistent: assert property (@(posedge clk) disable iff (rst)
    ptr_wrap[PW-1:0] == tail)
    else $error("key fifo pointers disagree with fill");

  a_pop_drains: assert property (@(posedge clk) disable iff (rst)
    accept && (in_data.operation == OP_POP) && (fill != '0) |=> fill == $past(fill) - 1'b1)
    else $error("pop did not remove one item");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    accept && (in_data.operation == OP_CLEAR) |=> (fill == '0) && (head == tail))
    else $error("clear left items in key fifo");

  a_scan_advances: assert property (@(posedge clk) disable iff (rst)
    do_scan |=> scan_col == $past(scan_col) + 2'd1)
    else $error("scan tick did not advance column");

endmodule
